// File: sv/nmtp_pkg.sv
// Package for the NMEA time sentence parser: character codes, phase and
// sentence type codes, record type and two-digit / hex digit helpers.
// No dependencies.
package nmtp_pkg;

    localparam int SLOTS = 9;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_UP_G   = 8'h47;
    localparam logic [7:0] CH_UP_R   = 8'h52;
    localparam logic [7:0] CH_UP_M   = 8'h4D;
    localparam logic [7:0] CH_UP_C   = 8'h43;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_L   = 8'h4C;
    localparam logic [7:0] CH_UP_N   = 8'h4E;
    localparam logic [7:0] CH_UP_P   = 8'h50;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_ID   = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_CSUM = 2'd3;

    localparam logic [1:0] TY_OTHER = 2'd0;
    localparam logic [1:0] TY_RMC   = 2'd1;
    localparam logic [1:0] TY_GGA   = 2'd2;

    typedef logic [SLOTS-1:0][7:0] t_slots;

    typedef struct packed {
        logic push;
        logic clear;
    } t_buf_ctrl;

    typedef struct packed {
        logic       kind;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
        logic [7:0] hundredths;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] status_char;
        logic [7:0] sat_count;
    } t_record;

    // 10*hi + lo - 11*'0', modulo 256
    function automatic logic [7:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
        two_digits = {hi[4:0], 3'b000} + {hi[6:0], 1'b0} + lo - 8'd16;
    endfunction

    function automatic logic [7:0] hex_value(input logic [7:0] b);
        if (b >= CH_LO_A && b <= CH_LO_F) begin
            hex_value = b - CH_LO_A + 8'd10;
        end else if (b >= CH_UP_A && b <= CH_UP_F) begin
            hex_value = b - CH_UP_A + 8'd10;
        end else begin
            hex_value = b - CH_ZERO;
        end
    endfunction

endpackage

// File: sv/nmtp_field_buf.sv
// Field buffer: collects the bytes of one comma-delimited field.
// Keeps the leading slots that get decoded; counts up to BUF_DEPTH.
// Depends on nmtp_pkg.
module nmtp_field_buf #(
    parameter int BUF_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nmtp_pkg::t_buf_ctrl i_ctrl,
    input  logic [7:0]          i_byte,
    output nmtp_pkg::t_slots    o_slots
);

    localparam int WP_W = $clog2(BUF_DEPTH + 1);

    nmtp_pkg::t_slots  r_slots;
    logic [WP_W-1:0]   r_wp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_slots <= '0;
            r_wp    <= '0;
        end else if (i_ctrl.push && r_wp < WP_W'(BUF_DEPTH)) begin
            for (int i = 0; i < nmtp_pkg::SLOTS; i++) begin
                if (r_wp == WP_W'(i)) begin
                    r_slots[i] <= i_byte;
                end
            end
            r_wp <= r_wp + 1'b1;
        end
    end

    assign o_slots = r_slots;

endmodule

// File: sv/nmtp_core.sv
// Sentence state machine: phase, checksum, ID match and field decode.
// Updates on each fired byte and flags a record at the line end.
// Depends on nmtp_pkg and nmtp_field_buf.
module nmtp_core #(
    parameter int BUF_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic              i_gga_enable,
    output logic              o_may_emit,
    output logic              o_emit,
    output nmtp_pkg::t_record o_record
);

    localparam logic [7:0] RMC_FLD_TIME   = 8'd0;
    localparam logic [7:0] RMC_FLD_STATUS = 8'd1;
    localparam logic [7:0] RMC_FLD_DATE   = 8'd8;
    localparam logic [7:0] GGA_FLD_SATS   = 8'd6;

    logic [1:0]          r_phase, n_phase;
    logic [1:0]          r_type, n_type;
    logic [7:0]          r_xor, n_xor;
    logic [7:0]          r_rsum, n_rsum;
    logic [7:0]          r_idx, n_idx;
    logic [3:0][7:0]     r_time, n_time;
    logic [2:0][7:0]     r_date, n_date;
    logic [7:0]          r_status, n_status;
    logic [7:0]          r_sat, n_sat;

    nmtp_pkg::t_buf_ctrl buf_ctrl;
    nmtp_pkg::t_slots    slots;
    logic                is_eol;
    logic [1:0]          id_type;
    logic                talker_ok;

    nmtp_field_buf #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (buf_ctrl),
        .i_byte  (i_byte),
        .o_slots (slots)
    );

    assign is_eol     = (i_byte == nmtp_pkg::CH_CR) || (i_byte == nmtp_pkg::CH_LF);
    assign o_may_emit = (r_phase == nmtp_pkg::PH_CSUM) && is_eol;

    assign talker_ok = (slots[1] == nmtp_pkg::CH_UP_A) || (slots[1] == nmtp_pkg::CH_UP_L) ||
                       (slots[1] == nmtp_pkg::CH_UP_N) || (slots[1] == nmtp_pkg::CH_UP_P);

    always_comb begin
        id_type = nmtp_pkg::TY_OTHER;
        if (slots[0] == nmtp_pkg::CH_UP_G && talker_ok) begin
            if (slots[2] == nmtp_pkg::CH_UP_R && slots[3] == nmtp_pkg::CH_UP_M &&
                slots[4] == nmtp_pkg::CH_UP_C) begin
                id_type = nmtp_pkg::TY_RMC;
            end else if (i_gga_enable && slots[2] == nmtp_pkg::CH_UP_G &&
                         slots[3] == nmtp_pkg::CH_UP_G && slots[4] == nmtp_pkg::CH_UP_A) begin
                id_type = nmtp_pkg::TY_GGA;
            end
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_xor    = r_xor;
        n_rsum   = r_rsum;
        n_idx    = r_idx;
        n_time   = r_time;
        n_date   = r_date;
        n_status = r_status;
        n_sat    = r_sat;
        buf_ctrl = '0;
        o_emit   = 1'b0;
        if (i_fire) begin
            if (i_byte == nmtp_pkg::CH_DOLLAR) begin
                n_phase  = nmtp_pkg::PH_ID;
                n_type   = nmtp_pkg::TY_OTHER;
                n_xor    = '0;
                n_rsum   = '0;
                n_idx    = '0;
                n_time   = '0;
                n_date   = '0;
                n_status = '0;
                n_sat    = '0;
                buf_ctrl.clear = 1'b1;
            end else if (r_phase == nmtp_pkg::PH_WAIT) begin
                n_phase = r_phase;
            end else if (i_byte == nmtp_pkg::CH_STAR) begin
                n_phase = nmtp_pkg::PH_CSUM;
                buf_ctrl.clear = 1'b1;
            end else if (r_phase == nmtp_pkg::PH_CSUM) begin
                if (!is_eol) begin
                    n_rsum = {r_rsum[3:0], 4'b0000} | nmtp_pkg::hex_value(i_byte);
                end else begin
                    o_emit  = (r_xor == r_rsum) && (r_type != nmtp_pkg::TY_OTHER);
                    n_rsum  = '0;
                    n_phase = nmtp_pkg::PH_WAIT;
                end
            end else begin
                n_xor = r_xor ^ i_byte;
                if (i_byte != nmtp_pkg::CH_COMMA) begin
                    buf_ctrl.push = 1'b1;
                end else begin
                    buf_ctrl.clear = 1'b1;
                    if (r_phase == nmtp_pkg::PH_ID) begin
                        n_type = id_type;
                        if (id_type != nmtp_pkg::TY_OTHER) begin
                            n_phase = nmtp_pkg::PH_DATA;
                        end
                    end else begin
                        n_idx = r_idx + 8'd1;
                        if (slots[0] != 8'd0) begin
                            if (r_type == nmtp_pkg::TY_RMC) begin
                                if (r_idx == RMC_FLD_TIME) begin
                                    n_time[0] = nmtp_pkg::two_digits(slots[0], slots[1]);
                                    n_time[1] = nmtp_pkg::two_digits(slots[2], slots[3]);
                                    n_time[2] = nmtp_pkg::two_digits(slots[4], slots[5]);
                                    n_time[3] = nmtp_pkg::two_digits(slots[7], slots[8]);
                                end else if (r_idx == RMC_FLD_STATUS) begin
                                    n_status = slots[0];
                                end else if (r_idx == RMC_FLD_DATE) begin
                                    n_date[0] = nmtp_pkg::two_digits(slots[0], slots[1]);
                                    n_date[1] = nmtp_pkg::two_digits(slots[2], slots[3]);
                                    n_date[2] = nmtp_pkg::two_digits(slots[4], slots[5]);
                                end
                            end else if (r_type == nmtp_pkg::TY_GGA) begin
                                if (r_idx == GGA_FLD_SATS) begin
                                    n_sat = nmtp_pkg::two_digits(slots[0], slots[1]);
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= nmtp_pkg::PH_WAIT;
            r_type   <= nmtp_pkg::TY_OTHER;
            r_xor    <= '0;
            r_rsum   <= '0;
            r_idx    <= '0;
            r_time   <= '0;
            r_date   <= '0;
            r_status <= '0;
            r_sat    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_xor    <= n_xor;
            r_rsum   <= n_rsum;
            r_idx    <= n_idx;
            r_time   <= n_time;
            r_date   <= n_date;
            r_status <= n_status;
            r_sat    <= n_sat;
        end
    end

    always_comb begin
        o_record.kind        = (r_type == nmtp_pkg::TY_GGA);
        o_record.hour        = r_time[0];
        o_record.minute      = r_time[1];
        o_record.second      = r_time[2];
        o_record.hundredths  = r_time[3];
        o_record.day         = r_date[0];
        o_record.month       = r_date[1];
        o_record.year        = r_date[2];
        o_record.status_char = r_status;
        o_record.sat_count   = r_sat;
    end

endmodule

// File: sv/nmea_time_sentence_parser.sv
// Top level of the NMEA time sentence parser: input word register, parser
// core, result register and the gga_enable configuration register.
// Depends on nmtp_pkg and nmtp_core.
//
//  channel   dir  handshake                 payload
//  s (byte)  in   i_s_tvalid / o_s_tready   i_s_tdata: rx_byte
//  m (rec)   out  o_m_tvalid / i_m_tready   o_m_tdata, o_m_tuser: record
//  cfg       in   i_cfg_valid / o_cfg_ready i_cfg_data: gga_enable
//
// One word per cycle; a word reaches the core the cycle after acceptance and
// a record appears at o_m the cycle after its line-end word is processed.
// A waiting record stalls only a line-end word; other words keep flowing.
// Reset is synchronous and active low; gga_enable resets to 1.
module nmea_time_sentence_parser #(
    parameter int BUF_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // hour, minute, second, hundredths, day, month,
                                     // year, status_char, sat_count (8 bits each)
    output logic [0:0]  o_m_tuser,   // [0] sentence_kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data   // gga_enable
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_gga_enable;
    logic              r_out_valid;
    nmtp_pkg::t_record r_out;

    logic              fire;
    logic              may_emit;
    logic              emit;
    nmtp_pkg::t_record record;

    assign fire       = r_in_valid && (!r_out_valid || i_m_tready || !may_emit);
    assign o_s_tready = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    nmtp_core #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte       (r_in_byte),
        .i_gga_enable (r_gga_enable),
        .o_may_emit   (may_emit),
        .o_emit       (emit),
        .o_record     (record)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_gga_enable <= 1'b1;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_gga_enable <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (fire && emit) begin
            r_out <= record;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {r_out.sat_count, r_out.status_char, r_out.year, r_out.month,
                         r_out.day, r_out.hundredths, r_out.second, r_out.minute,
                         r_out.hour};

endmodule

// File: tb/sv/tb_nmea_time_sentence_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for nmea_time_sentence_parser: directed and random byte
// streams of RMC/GGA sentences, checked record by record against a built-in parser.
// Depends on nmtp_pkg and nmea_time_sentence_parser.
module tb_nmea_time_sentence_parser;
    import nmtp_pkg::*;

    localparam int BUF_DEPTH = 16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UP_V  = 8'h56;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic [7:0] F_TIME   = 8'd0;
    localparam logic [7:0] F_STATUS = 8'd1;
    localparam logic [7:0] F_SATS   = 8'd6;
    localparam logic [7:0] F_DATE   = 8'd8;

    localparam logic [7:0] TALKERS [4] = '{CH_UP_A, CH_UP_L, CH_UP_N, CH_UP_P};

    typedef enum int {
        SH_RMC, SH_GGA, SH_BAD_ID, SH_NOISE, SH_CUT, SH_LONG, SH_WRAP, SH_NO_DATA
    } t_shape;

    typedef struct packed {
        logic [7:0] word;
        logic       typed;
        logic       kind;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [24] = '{
        '{8'hFF, 1'b0, 1'b0}, '{CH_NUL, 1'b0, 1'b0},
        '{CH_DOLLAR, 1'b0, 1'b0}, '{CH_UP_G, 1'b0, 1'b0}, '{CH_UP_N, 1'b0, 1'b0},
        '{CH_UP_R, 1'b0, 1'b0}, '{CH_UP_M, 1'b0, 1'b0}, '{CH_UP_C, 1'b0, 1'b0},
        '{CH_COMMA, 1'b0, 1'b0}, '{CH_STAR, 1'b0, 1'b0},
        '{CH_ZERO + 8'd7, 1'b0, 1'b0}, '{CH_ZERO + 8'd9, 1'b0, 1'b0},
        '{CH_CR, 1'b1, 1'b0},
        '{CH_DOLLAR, 1'b0, 1'b0}, '{CH_UP_G, 1'b0, 1'b0}, '{CH_UP_P, 1'b0, 1'b0},
        '{CH_UP_G, 1'b0, 1'b0}, '{CH_UP_G, 1'b0, 1'b0}, '{CH_UP_A, 1'b0, 1'b0},
        '{CH_COMMA, 1'b0, 1'b0}, '{CH_STAR, 1'b0, 1'b0},
        '{CH_ZERO + 8'd7, 1'b0, 1'b0}, '{CH_LO_A, 1'b0, 1'b0},
        '{CH_LF, 1'b1, 1'b1}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    t_record    pending_records [$];
    logic [7:0] body [$];
    int         errors      = 0;
    int         words_used  = 0;
    bit         steady      = 1'b0;

    // parser state
    logic       gga_on;
    logic [1:0] cur_phase;
    logic [1:0] cur_type;
    logic [7:0] sum_run;
    logic [7:0] sum_rx;
    logic [7:0] field_no;
    logic [7:0] fbuf [BUF_DEPTH];
    int         fill;
    logic [7:0] time_val [4];
    logic [7:0] date_val [3];
    logic [7:0] status_val;
    logic [7:0] sats_val;

    nmea_time_sentence_parser #(.BUF_DEPTH(BUF_DEPTH)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void wipe_field();
        foreach (fbuf[k]) fbuf[k] = '0;
        fill = 0;
    endfunction

    function automatic void wipe_sentence();
        wipe_field();
        cur_phase  = PH_WAIT;
        cur_type   = TY_OTHER;
        sum_run    = '0;
        sum_rx     = '0;
        field_no   = '0;
        foreach (time_val[k]) time_val[k] = '0;
        foreach (date_val[k]) date_val[k] = '0;
        status_val = '0;
        sats_val   = '0;
    endfunction

    function automatic logic [7:0] pair_at(input int at);
        return 8'(10 * int'(fbuf[at]) + int'(fbuf[at + 1]) - 11 * int'(CH_ZERO));
    endfunction

    function automatic logic [7:0] nibble_of(input logic [7:0] b);
        if (b inside {[CH_LO_A:CH_LO_F]}) return 8'(b - CH_LO_A + 10);
        if (b inside {[CH_UP_A:CH_UP_F]}) return 8'(b - CH_UP_A + 10);
        return 8'(b - CH_ZERO);
    endfunction

    function automatic logic [1:0] id_kind();
        if (fbuf[0] != CH_UP_G || !(fbuf[1] inside {CH_UP_A, CH_UP_L, CH_UP_N, CH_UP_P}))
            return TY_OTHER;
        if (fbuf[2] == CH_UP_R && fbuf[3] == CH_UP_M && fbuf[4] == CH_UP_C) return TY_RMC;
        if (gga_on && fbuf[2] == CH_UP_G && fbuf[3] == CH_UP_G && fbuf[4] == CH_UP_A)
            return TY_GGA;
        return TY_OTHER;
    endfunction

    function automatic void take_field();
        if (fbuf[0] == CH_NUL) return;
        if (cur_type == TY_RMC) begin
            if (field_no == F_TIME) begin
                time_val[0] = pair_at(0);
                time_val[1] = pair_at(2);
                time_val[2] = pair_at(4);
                time_val[3] = pair_at(7);
            end else if (field_no == F_STATUS) begin
                status_val = fbuf[0];
            end else if (field_no == F_DATE) begin
                date_val[0] = pair_at(0);
                date_val[1] = pair_at(2);
                date_val[2] = pair_at(4);
            end
        end else if (cur_type == TY_GGA && field_no == F_SATS) begin
            sats_val = pair_at(0);
        end
    endfunction

    task automatic parse_word(input logic [7:0] c, output bit got, output t_record rec);
        got = 1'b0;
        rec = '0;
        if (c == CH_DOLLAR) begin
            wipe_sentence();
            cur_phase = PH_ID;
            return;
        end
        if (cur_phase == PH_WAIT) return;
        if (c == CH_STAR) begin
            cur_phase = PH_CSUM;
            wipe_field();
            return;
        end
        if (cur_phase == PH_CSUM) begin
            if (c != CH_CR && c != CH_LF) begin
                sum_rx = {sum_rx[3:0], 4'h0} | nibble_of(c);
                return;
            end
            if (sum_rx == sum_run && cur_type != TY_OTHER) begin
                got             = 1'b1;
                rec.kind        = (cur_type == TY_GGA);
                rec.hour        = time_val[0];
                rec.minute      = time_val[1];
                rec.second      = time_val[2];
                rec.hundredths  = time_val[3];
                rec.day         = date_val[0];
                rec.month       = date_val[1];
                rec.year        = date_val[2];
                rec.status_char = status_val;
                rec.sat_count   = sats_val;
            end
            sum_rx    = '0;
            cur_phase = PH_WAIT;
            return;
        end
        sum_run ^= c;
        if (c != CH_COMMA) begin
            if (fill < BUF_DEPTH) begin
                fbuf[fill] = c;
                fill++;
            end
            return;
        end
        if (cur_phase == PH_ID) begin
            cur_type = id_kind();
            if (cur_type != TY_OTHER) cur_phase = PH_DATA;
        end else begin
            take_field();
            field_no++;
        end
        wipe_field();
    endtask

    task automatic send_word(input logic [7:0] b, input bit has_typed = 1'b0,
                             input t_record typed = '0);
        bit      got;
        t_record rec;
        while (!steady && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_used++;
        parse_word(b, got, rec);
        if (has_typed) pending_records.push_back(typed);
        else if (got) pending_records.push_back(rec);
    endtask

    // hold the input idle until every record is out, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_gga(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        gga_on = v;
    endtask

    function automatic logic [7:0] content_byte();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 80) return CH_ZERO + 8'($urandom_range(0, 9));
        b = (r < 92) ? 8'($urandom_range(CH_SPACE, CH_TILDE)) : 8'($urandom);
        if (b == CH_DOLLAR || b == CH_STAR || b == CH_COMMA) b = CH_UP_G;
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(v) - 8'd10;
    endfunction

    task automatic add_id(input logic [1:0] kind, input bit spoil);
        logic [7:0] id [5];
        id[0] = CH_UP_G;
        id[1] = TALKERS[$urandom_range(0, 3)];
        if (kind == TY_RMC) begin
            id[2] = CH_UP_R;
            id[3] = CH_UP_M;
            id[4] = CH_UP_C;
        end else begin
            id[2] = CH_UP_G;
            id[3] = CH_UP_G;
            id[4] = CH_UP_A;
        end
        if (spoil) id[$urandom_range(0, 4)] = 8'($urandom_range(CH_UP_A, CH_UP_Z));
        foreach (id[k]) body.push_back(id[k]);
        if ($urandom_range(0, 9) == 0) body.push_back(content_byte());
    endtask

    task automatic add_field(input logic [7:0] slot, input logic [1:0] kind,
                             input bit long_one, input bit bare);
        int n;
        int r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3) body.push_back(CH_NUL);
        if (long_one) begin
            n = $urandom_range(17, 24);
        end else if (bare) begin
            n = 0;
        end else if (kind == TY_RMC && slot == F_STATUS) begin
            if (r < 40) body.push_back(CH_UP_A);
            else if (r < 80) body.push_back(CH_UP_V);
            else if (r < 90) body.push_back(content_byte());
            n = 0;
        end else if (kind == TY_RMC && slot == F_TIME) begin
            n = (r < 80) ? 9 : $urandom_range(0, 12);
        end else if (kind == TY_RMC && slot == F_DATE) begin
            n = (r < 80) ? 6 : $urandom_range(0, 8);
        end else if (kind == TY_GGA && slot == F_SATS) begin
            n = (r < 80) ? 2 : $urandom_range(0, 3);
        end else begin
            n = $urandom_range(0, 2);
        end
        for (int k = 0; k < n; k++)
            body.push_back((kind == TY_RMC && slot == F_TIME && k == 6) ? CH_DOT : content_byte());
    endtask

    task automatic send_sentence(input t_shape shape);
        logic [1:0] want;
        logic [7:0] sum;
        logic [7:0] junk;
        int         nf;
        int         longf;
        int         stop;
        int         r;
        body = {};
        want = ($urandom_range(0, 99) < 55) ? TY_RMC : TY_GGA;
        if (shape == SH_NOISE) begin
            repeat ($urandom_range(1, 8)) send_word(8'($urandom));
            return;
        end
        add_id(want, shape == SH_BAD_ID);
        if (shape != SH_NO_DATA) body.push_back(CH_COMMA);
        if (shape == SH_BAD_ID && $urandom_range(0, 1)) begin
            add_id(want, 1'b0);
            body.push_back(CH_COMMA);
        end
        if (shape == SH_WRAP) nf = 256 + $urandom_range(1, 10);
        else if (shape == SH_NO_DATA) nf = 0;
        else nf = $urandom_range(1, (want == TY_RMC) ? 11 : 9);
        longf = (shape == SH_LONG) ? $urandom_range(0, nf - 1) : -1;
        for (int i = 0; i < nf; i++) begin
            if (i != 0) body.push_back(CH_COMMA);
            add_field(8'(i), want, i == longf, i >= 12 && i < 256);
        end
        sum = '0;
        foreach (body[k]) sum ^= body[k];
        stop = (shape == SH_CUT) ? $urandom_range(0, body.size()) : body.size();
        send_word(CH_DOLLAR);
        for (int k = 0; k < stop; k++) send_word(body[k]);
        if (shape == SH_CUT) return;
        send_word(CH_STAR);
        r = $urandom_range(0, 99);
        if (r < 10) send_word(hex_char(4'($urandom)));
        if (r < 90) begin
            send_word(hex_char(sum[7:4]));
            send_word(hex_char(sum[3:0]));
        end else begin
            repeat ($urandom_range(0, 3)) begin
                junk = 8'($urandom);
                if (junk == CH_DOLLAR || junk == CH_CR || junk == CH_LF) junk = CH_UP_F;
                send_word(junk);
            end
        end
        send_word($urandom_range(0, 1) ? CH_CR : CH_LF);
        if ($urandom_range(0, 4) == 0) send_word(CH_LF);
    endtask

    task automatic match_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t %s: expected %02h, actual %02h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge clk) begin : check_records
        t_record want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_records.size() == 0) begin
                $display("%0t record: expected none, actual kind %0d data %h",
                         $time, m_tuser[0], m_tdata);
                errors++;
            end else begin
                want = pending_records.pop_front();
                match_field("sentence_kind", 8'(want.kind), 8'(m_tuser[0]));
                match_field("hour", want.hour, m_tdata[7:0]);
                match_field("minute", want.minute, m_tdata[15:8]);
                match_field("second", want.second, m_tdata[23:16]);
                match_field("hundredths", want.hundredths, m_tdata[31:24]);
                match_field("day", want.day, m_tdata[39:32]);
                match_field("month", want.month, m_tdata[47:40]);
                match_field("year", want.year, m_tdata[55:48]);
                match_field("status_char", want.status_char, m_tdata[63:56]);
                match_field("sat_count", want.sat_count, m_tdata[71:64]);
            end
        end
    end

    initial begin
        int      start;
        int      phase_mark;
        int      setting_no;
        int      n_sent;
        int      r;
        t_shape  shape;
        t_record typed;
        gga_on = 1'b1;
        wipe_sentence();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_gga(1'b1);

        foreach (DIR_ROWS[k]) begin
            typed      = '0;
            typed.kind = DIR_ROWS[k].kind;
            send_word(DIR_ROWS[k].word, DIR_ROWS[k].typed, typed);
        end

        start      = words_used;
        phase_mark = words_used;
        setting_no = 0;
        n_sent     = 0;
        while (words_used - start < 1950) begin
            if (n_sent == 0 || words_used - phase_mark >= 330) begin
                drain();
                if (setting_no == 0) write_gga(1'b0);
                else if (setting_no == 1) write_gga(1'b1);
                else write_gga(1'($urandom_range(0, 1)));
                setting_no++;
                phase_mark = words_used;
            end
            steady = (words_used - start >= 700) && (words_used - start < 1100);
            r = $urandom_range(0, 99);
            if (n_sent == 5) shape = SH_WRAP;
            else if (r < 38) shape = SH_RMC;
            else if (r < 62) shape = SH_GGA;
            else if (r < 70) shape = SH_BAD_ID;
            else if (r < 78) shape = SH_NOISE;
            else if (r < 86) shape = SH_CUT;
            else if (r < 94) shape = SH_LONG;
            else if (r < 96) shape = SH_WRAP;
            else shape = SH_NO_DATA;
            send_sentence(shape);
            n_sent++;
        end
        steady = 1'b0;
        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
